// ----- rtl/ntc_adc_to_celsius_top_assert.svh -----
// Assertion macros for the NTC temperature block.
// Included by the top level; expects clk and rst_n in scope.
`ifndef NTC_ADC_TO_CELSIUS_TOP_ASSERT_SVH
`define NTC_ADC_TO_CELSIUS_TOP_ASSERT_SVH

// same-cycle implication
`define NTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ntc_pkg.sv -----
// Shared types and constants for the NTC temperature block.
// No dependencies.
package ntc_pkg;

  localparam int SAMPLES_AVERAGED_DEF = 10;
  localparam int ADC_FULL_SCALE_DEF   = 1024;

  localparam int ADC_W  = 10;
  localparam int SUM_W  = 14;
  localparam int CNT_W  = 4;
  localparam int FS_W   = 13;
  localparam int BETA_W = 14;
  localparam int OHM_W  = 20;
  localparam int NOMC_W = 7;
  localparam int TEMP_W = 16;
  localparam int IDX_W  = 8;
  localparam int DATA_W = 32;

  localparam int DIV_NW = 56;
  localparam int DIV_DW = 40;
  localparam int DIV_CW = 6;

  localparam logic [IDX_W-1:0] REG_BETA    = 8'd0;
  localparam logic [IDX_W-1:0] REG_SERIES  = 8'd1;
  localparam logic [IDX_W-1:0] REG_NOMINAL = 8'd2;
  localparam logic [IDX_W-1:0] REG_NOMC    = 8'd3;

  localparam logic [BETA_W-1:0] BETA_RST    = 14'd3900;
  localparam logic [OHM_W-1:0]  SERIES_RST  = 20'd10000;
  localparam logic [OHM_W-1:0]  NOMINAL_RST = 20'd10000;
  localparam logic [NOMC_W-1:0] NOMC_RST    = 7'd25;

  localparam logic [31:0] LN2_Q30      = 32'd744261118;
  localparam logic [15:0] KELVIN_CENTI = 16'd27315;
  localparam logic [16:0] TC_MAX       = 17'd60082;  // 32767 + 27315
  localparam logic [4:0]  LOG_LAST     = 5'd23;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCUM, OP_GROUP, OP_MEAN, OP_FAULT, OP_MUL_NUM, OP_LOG_LOAD,
    OP_NORM_SHIFT, OP_LOG_INIT, OP_SQUARE, OP_SQ_NORM, OP_SAVE_NUM, OP_SAVE_DEN,
    OP_MUL_LN, OP_MUL_T0, OP_DIV_TERM, OP_SAVE_TERM, OP_CALC_D, OP_DIV_T,
    OP_FINISH, OP_PUBLISH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic group_last;
    logic div_busy;
    logic mean_bad;
    logic x_top;
    logic last_step;
    logic d_nonpos;
    logic out_full;
  } sts_t;

endpackage

// ----- rtl/ntc_if.sv -----
// Handshake channel interfaces: sample in, temperature out, register writes.
// Depends on ntc_pkg.
interface ntc_in_if;
  logic                       valid;
  logic                       ready;
  logic [ntc_pkg::ADC_W-1:0]  adc_sample;
  modport source (output valid, adc_sample, input ready);
  modport sink   (input valid, adc_sample, output ready);
endinterface

interface ntc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ntc_pkg::TEMP_W-1:0] temperature_centi;
  logic                              sensor_fault;
  modport source (output valid, temperature_centi, sensor_fault, input ready);
  modport sink   (input valid, temperature_centi, sensor_fault, output ready);
endinterface

interface ntc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ntc_pkg::IDX_W-1:0]   index;
  logic [ntc_pkg::DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/ntc_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Depends on ntc_pkg.
module ntc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ntc_pkg::DIV_NW-1:0] num,
  input  logic [ntc_pkg::DIV_DW-1:0] den,
  output logic                       busy,
  output logic [ntc_pkg::DIV_NW-1:0] quo
);
  import ntc_pkg::*;

  localparam logic [DIV_CW-1:0] LAST = DIV_CW'(DIV_NW - 1);

  logic              busy_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW-1:0] rem_r, den_r;
  logic [DIV_DW:0]   rem_sh, diff;
  logic              fits;

  assign rem_sh = {rem_r, quo_r[DIV_NW-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LAST) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_NW-2:0], fits};
      rem_r <= fits ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
endmodule

// ----- rtl/ntc_dp.sv -----
// Datapath: accumulator, config registers, shared multiplier, log2 unit,
// serial divider and output register. Depends on ntc_pkg and ntc_div.
module ntc_dp #(
  parameter int SAMPLES_AVERAGED = ntc_pkg::SAMPLES_AVERAGED_DEF,
  parameter int ADC_FULL_SCALE   = ntc_pkg::ADC_FULL_SCALE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ntc_pkg::cmd_t                     cmd,
  output ntc_pkg::sts_t                     sts,
  input  logic [ntc_pkg::ADC_W-1:0]         adc_sample,
  input  logic                              cfg_write,
  input  logic [ntc_pkg::IDX_W-1:0]         cfg_index,
  input  logic [ntc_pkg::DATA_W-1:0]        cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [ntc_pkg::TEMP_W-1:0] out_temp,
  output logic                              out_fault
);
  import ntc_pkg::*;

  localparam logic [4:0]      N_L  = 5'(SAMPLES_AVERAGED);
  localparam logic [FS_W-1:0] FS_L = FS_W'(ADC_FULL_SCALE);
  // ceil(2^19 / N): exact floor(sum / N) for any 14-bit sum
  localparam logic [19:0]     RECIP_N = 20'(((1 << 19) + SAMPLES_AVERAGED - 1) /
                                            SAMPLES_AVERAGED);
  // ceil(2^33 / 5): exact floor(y / 5) for y below 2^30
  localparam logic [31:0]     RECIP_5 = 32'd1717986919;

  logic [SUM_W-1:0]  sum_r, sum_add;
  logic [CNT_W-1:0]  count_r;
  logic [BETA_W-1:0] beta_r;
  logic [OHM_W-1:0]  series_r, nominal_r;
  logic [NOMC_W-1:0] nomc_r;
  logic [SUM_W-1:0]  mean_r;
  logic [63:0]       prod_r;
  logic [39:0]       x_r;
  logic [5:0]        sh_r;
  logic [30:0]       y_r;
  logic [23:0]       frac_r;
  logic [4:0]        step_r;
  logic [29:0]       lnum_r, lden_r, mag, log_val;
  logic              neg_r;
  logic [39:0]       term_r;
  logic signed [41:0] d_r, d_nxt;
  logic [TEMP_W-1:0] res_temp_r, tcel;
  logic              res_fault_r;
  logic              out_valid_r, out_fault_r;
  logic [TEMP_W-1:0] out_temp_r;
  logic [15:0]       t0c;
  logic [31:0]       mul_a, mul_b, sq_p;
  logic [63:0]       mul_p;
  logic [16:0]       tc_lo;
  logic [29:0]       lnmag_r;
  logic [31:0]       ln_x3;
  logic [8:0]        t0_k;

  logic              div_start, div_busy;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den;

  assign sum_add = sum_r + {{(SUM_W-ADC_W){1'b0}}, adc_sample};
  assign t0c     = 16'(nomc_r) * 16'd100 + KELVIN_CENTI;
  // T0 / 100 split as (nomc + 273) plus 15/100 of a unit
  assign t0_k    = {2'd0, nomc_r} + 9'd273;
  assign ln_x3   = {2'd0, lnmag_r} + {1'b0, lnmag_r, 1'b0};
  assign log_val = {6'd39 - sh_r, frac_r};
  assign mag     = (lnum_r < lden_r) ? (lden_r - lnum_r) : (lnum_r - lden_r);
  assign sq_p    = prod_r[61:30];
  assign mul_p   = mul_a * mul_b;

  // one shared multiplier, operands picked by the current command
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MEAN: begin
        mul_a = {18'd0, mean_r};
        mul_b = {12'd0, RECIP_N};
      end
      OP_MUL_NUM: begin
        mul_a = {12'd0, series_r};
        mul_b = {18'd0, mean_r};
      end
      OP_SAVE_NUM: begin
        mul_a = {12'd0, nominal_r};
        mul_b = {19'd0, FS_L - mean_r[FS_W-1:0]};
      end
      OP_SQUARE: begin
        mul_a = {1'b0, y_r};
        mul_b = {1'b0, y_r};
      end
      OP_MUL_LN: begin
        mul_a = {2'd0, mag};
        mul_b = LN2_Q30;
      end
      OP_MUL_T0: begin
        mul_a = prod_r[61:30];
        mul_b = {23'd0, t0_k};
      end
      OP_DIV_TERM: begin
        // floor(3 * ln / 4), then divided by 5
        mul_a = {2'd0, ln_x3[31:2]};
        mul_b = RECIP_5;
      end
      OP_CALC_D: begin
        mul_a = {18'd0, beta_r};
        mul_b = {16'd0, t0c};
      end
      default: ;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      OP_DIV_T: begin
        // (B*T0 << 24) + D/2, D known positive here
        div_start = 1'b1;
        div_num   = {2'd0, prod_r[29:0], 24'd0} + {15'd0, d_r[41:1]};
        div_den   = d_r[39:0];
      end
      default: ;
    endcase
  end

  ntc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  assign d_nxt = neg_r ? ($signed({4'd0, beta_r, 24'd0}) - $signed({2'd0, term_r}))
                       : ($signed({4'd0, beta_r, 24'd0}) + $signed({2'd0, term_r}));

  assign tc_lo = div_quo[16:0] - {1'b0, KELVIN_CENTI};
  assign tcel  = ((|div_quo[DIV_NW-1:17]) || (div_quo[16:0] > TC_MAX))
                 ? 16'h7FFF : tc_lo[15:0];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      count_r     <= '0;
      beta_r      <= BETA_RST;
      series_r    <= SERIES_RST;
      nominal_r   <= NOMINAL_RST;
      nomc_r      <= NOMC_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_ACCUM) begin
        sum_r   <= sum_add;
        count_r <= count_r + 1'b1;
      end else if (cmd.op == OP_GROUP) begin
        sum_r   <= '0;
        count_r <= '0;
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_BETA:    beta_r    <= cfg_data[BETA_W-1:0];
          REG_SERIES:  series_r  <= cfg_data[OHM_W-1:0];
          REG_NOMINAL: nominal_r <= cfg_data[OHM_W-1:0];
          REG_NOMC:    nomc_r    <= cfg_data[NOMC_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_PUBLISH)  out_valid_r <= 1'b1;
      else if (out_ready)        out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      // group sum parked in mean_r until the reciprocal multiply
      OP_GROUP: mean_r <= sum_add;
      OP_MEAN:  mean_r <= mul_p[19 +: SUM_W];
      OP_FAULT: begin
        res_temp_r  <= '0;
        res_fault_r <= 1'b1;
      end
      OP_MUL_NUM: prod_r <= mul_a * mul_b;
      OP_MUL_T0: begin
        lnmag_r <= prod_r[59:30];
        prod_r  <= mul_p;
      end
      OP_LOG_LOAD: begin
        x_r  <= prod_r[39:0];
        sh_r <= '0;
      end
      OP_NORM_SHIFT: begin
        x_r  <= {x_r[38:0], 1'b0};
        sh_r <= sh_r + 1'b1;
      end
      OP_LOG_INIT: begin
        y_r    <= x_r[39:9];
        frac_r <= '0;
        step_r <= '0;
      end
      OP_SQUARE: prod_r <= mul_a * mul_b;
      OP_SQ_NORM: begin
        y_r    <= sq_p[31] ? sq_p[31:1] : sq_p[30:0];
        frac_r <= {frac_r[22:0], sq_p[31]};
        step_r <= step_r + 1'b1;
      end
      OP_SAVE_NUM: begin
        lnum_r <= log_val;
        prod_r <= mul_a * mul_b;
      end
      OP_SAVE_DEN: lden_r <= log_val;
      OP_MUL_LN: begin
        neg_r  <= lnum_r < lden_r;
        prod_r <= mul_a * mul_b;
      end
      OP_DIV_TERM: begin
        term_r <= prod_r[39:0];
        prod_r <= mul_p;
      end
      OP_SAVE_TERM: term_r <= term_r + {12'd0, prod_r[60:33]};
      OP_CALC_D: begin
        d_r    <= d_nxt;
        prod_r <= mul_a * mul_b;
      end
      OP_FINISH: begin
        res_temp_r  <= tcel;
        res_fault_r <= 1'b0;
      end
      OP_PUBLISH: begin
        out_temp_r  <= res_temp_r;
        out_fault_r <= res_fault_r;
      end
      default: ;
    endcase
  end

  assign sts.group_last = {1'b0, count_r} == (N_L - 5'd1);
  assign sts.div_busy   = div_busy;
  assign sts.mean_bad   = (mean_r == '0) || (mean_r >= {1'b0, FS_L}) ||
                          (series_r == '0) || (nominal_r == '0) || (beta_r == '0);
  assign sts.x_top      = x_r[39];
  assign sts.last_step  = step_r == LOG_LAST;
  assign sts.d_nonpos   = d_r[41] || (d_r == '0);
  assign sts.out_full   = out_valid_r;

  assign out_valid = out_valid_r;
  assign out_temp  = $signed(out_temp_r);
  assign out_fault = out_fault_r;
endmodule

// ----- rtl/ntc_ctrl.sv -----
// Sequencer for the NTC datapath: accumulate, mean, two logs, term, divide.
// Depends on ntc_pkg.
module ntc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ntc_pkg::sts_t sts,
  output ntc_pkg::cmd_t cmd
);
  import ntc_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_MWAIT  = 16'h0002,
    S_MCHK   = 16'h0004,
    S_LOAD   = 16'h0008,
    S_NORM   = 16'h0010,
    S_SQ     = 16'h0020,
    S_SQN    = 16'h0040,
    S_LOGEND = 16'h0080,
    S_LN     = 16'h0100,
    S_TERM   = 16'h0200,
    S_TDIV   = 16'h0400,
    S_TWAIT  = 16'h0800,
    S_DCALC  = 16'h1000,
    S_DCHK   = 16'h2000,
    S_QWAIT  = 16'h4000,
    S_PUB    = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic   den_pass_r, den_pass_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt    = state_r;
    den_pass_nxt = den_pass_r;
    cmd.op       = OP_NONE;
    case (state_r)
      S_IDLE: if (in_valid) begin
        if (sts.group_last) begin
          cmd.op    = OP_GROUP;
          state_nxt = S_MWAIT;
        end else begin
          cmd.op = OP_ACCUM;
        end
      end
      S_MWAIT: if (!sts.div_busy) begin
        cmd.op    = OP_MEAN;
        state_nxt = S_MCHK;
      end
      S_MCHK: begin
        if (sts.mean_bad) begin
          cmd.op    = OP_FAULT;
          state_nxt = S_PUB;
        end else begin
          cmd.op       = OP_MUL_NUM;
          den_pass_nxt = 1'b0;
          state_nxt    = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.op    = OP_LOG_LOAD;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (sts.x_top) begin
          cmd.op    = OP_LOG_INIT;
          state_nxt = S_SQ;
        end else begin
          cmd.op = OP_NORM_SHIFT;
        end
      end
      S_SQ: begin
        cmd.op    = OP_SQUARE;
        state_nxt = S_SQN;
      end
      S_SQN: begin
        cmd.op    = OP_SQ_NORM;
        state_nxt = sts.last_step ? S_LOGEND : S_SQ;
      end
      S_LOGEND: begin
        if (den_pass_r) begin
          cmd.op    = OP_SAVE_DEN;
          state_nxt = S_LN;
        end else begin
          // also starts the denominator product
          cmd.op       = OP_SAVE_NUM;
          den_pass_nxt = 1'b1;
          state_nxt    = S_LOAD;
        end
      end
      S_LN: begin
        cmd.op    = OP_MUL_LN;
        state_nxt = S_TERM;
      end
      S_TERM: begin
        cmd.op    = OP_MUL_T0;
        state_nxt = S_TDIV;
      end
      S_TDIV: begin
        cmd.op    = OP_DIV_TERM;
        state_nxt = S_TWAIT;
      end
      S_TWAIT: if (!sts.div_busy) begin
        cmd.op    = OP_SAVE_TERM;
        state_nxt = S_DCALC;
      end
      S_DCALC: begin
        cmd.op    = OP_CALC_D;
        state_nxt = S_DCHK;
      end
      S_DCHK: begin
        if (sts.d_nonpos) begin
          cmd.op    = OP_FAULT;
          state_nxt = S_PUB;
        end else begin
          cmd.op    = OP_DIV_T;
          state_nxt = S_QWAIT;
        end
      end
      S_QWAIT: if (!sts.div_busy) begin
        cmd.op    = OP_FINISH;
        state_nxt = S_PUB;
      end
      S_PUB: if (!sts.out_full) begin
        cmd.op    = OP_PUBLISH;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      den_pass_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      den_pass_r <= den_pass_nxt;
    end
  end
endmodule

// ----- rtl/ntc_adc_to_celsius_top.sv -----
// A sample that does not close a group is accepted without a stall. The
// closing sample starts the conversion (a fault skips the later steps):
// two 24-step squaring log loops, the leading-one shifts and one 56-step
// serial divide. Input stalls from the closing sample until the result
// is registered; the result register holds while the next group accumulates.
// Synchronous active-low reset clears accumulator, sequencer, output valid.
module ntc_adc_to_celsius_top #(
  parameter int SAMPLES_AVERAGED = ntc_pkg::SAMPLES_AVERAGED_DEF,
  parameter int ADC_FULL_SCALE   = ntc_pkg::ADC_FULL_SCALE_DEF
) (
  input logic      clk,
  input logic      rst_n,
  ntc_in_if.sink   in_ch,
  ntc_out_if.source out_ch,
  ntc_cfg_if.sink  cfg_ch
);
  import ntc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic group_close;
  logic out_take;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  ntc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ntc_dp #(
    .SAMPLES_AVERAGED (SAMPLES_AVERAGED),
    .ADC_FULL_SCALE   (ADC_FULL_SCALE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .adc_sample (in_ch.adc_sample),
    .cfg_write  (cfg_ch.valid),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_temp   (out_ch.temperature_centi),
    .out_fault  (out_ch.sensor_fault)
  );

  assign group_close = in_ch.valid && in_ready && sts.group_last;
  assign out_take    = out_ch.valid && out_ch.ready;

`include "ntc_adc_to_celsius_top_assert.svh"

  `NTC_ASSERT_NOW(a_busy_not_ready, sts.div_busy, !in_ready, "request taken while dividing")
  `NTC_ASSERT_NEXT(a_group_stall, group_close, !in_ready, "input open after group close")
  `NTC_ASSERT_NEXT(a_out_drains, out_take, !out_ch.valid, "result reloaded when taken")

endmodule

// ----- verif/tb_ntc_adc_to_celsius_top.sv -----
// Self-checking bench for the NTC thermistor temperature block.
// Predicts each group result in fixed point; depends on ntc_pkg, ntc_if and the top level.
module tb_ntc_adc_to_celsius_top;
  import ntc_pkg::*;

  localparam int GROUP_LEN    = SAMPLES_AVERAGED_DEF;
  localparam int FULL_SCALE   = ADC_FULL_SCALE_DEF;
  localparam int TAIL_CYCLES  = 600;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam longint unsigned LN2_MUL = 64'd744261118;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic                     fault;
  } reading_t;

  logic clk;
  logic rst_n;

  ntc_in_if  in_ch();
  ntc_out_if out_ch();
  ntc_cfg_if cfg_ch();

  ntc_adc_to_celsius_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // predictor state
  logic [BETA_W-1:0] beta_k;
  logic [OHM_W-1:0]  series_r;
  logic [OHM_W-1:0]  nominal_r;
  logic [NOMC_W-1:0] nominal_c;
  logic [SUM_W-1:0]  acc_sum;
  logic [CNT_W-1:0]  acc_cnt;

  logic [ADC_W-1:0] sample_queue[$];
  reading_t         expected_readings[$];
  int  mismatch_cnt;
  int  cycle_cnt;
  bit  feed_hold;

  function automatic longint unsigned log2_q24(longint unsigned x);
    int k;
    longint unsigned t, y, frac;
    k = 0; t = x; frac = 0;
    while (t > 1) begin
      t >>= 1;
      k++;
    end
    y = (k <= 30) ? (x << (30 - k)) : (x >> (k - 30));
    for (int i = 0; i < 24; i++) begin
      y = (y * y) >> 30;
      frac <<= 1;
      if (y >= (64'd2 << 30)) begin
        y >>= 1;
        frac |= 1;
      end
    end
    return (longint'(k) << 24) | frac;
  endfunction

  function automatic reading_t celsius_of_mean(longint unsigned m);
    reading_t r;
    longint unsigned num, den, ln_n, ln_d, mag, lnmag, t0c, term, bq;
    longint d, n, tc, tcel;
    bit neg;
    r.temp = '0;
    r.fault = 1'b1;
    if (m == 0 || m >= FULL_SCALE) return r;
    if (series_r == 0 || nominal_r == 0 || beta_k == 0) return r;
    num = longint'(series_r) * m;
    den = longint'(nominal_r) * (FULL_SCALE - m);
    ln_n = log2_q24(num);
    ln_d = log2_q24(den);
    neg = ln_n < ln_d;
    mag = neg ? ln_d - ln_n : ln_n - ln_d;
    lnmag = (mag * LN2_MUL) >> 30;
    t0c = longint'(nominal_c) * 100 + 27315;
    term = (lnmag * t0c) / 100;
    bq = longint'(beta_k) << 24;
    d = neg ? longint'(bq) - longint'(term) : longint'(bq) + longint'(term);
    if (d <= 0) return r;
    n = longint'((longint'(beta_k) * t0c) << 24);
    tc = (n + d / 2) / d;
    tcel = tc - 27315;
    if (tcel > 32767) tcel = 32767;
    if (tcel < -32768) tcel = -32768;
    r.temp = tcel[15:0];
    r.fault = 1'b0;
    return r;
  endfunction

  function automatic void absorb_sample(logic [ADC_W-1:0] s);
    longint unsigned m;
    acc_sum = acc_sum + s;
    if (acc_cnt + 1 < GROUP_LEN) begin
      acc_cnt = acc_cnt + 1;
      return;
    end
    m = acc_sum / GROUP_LEN;
    acc_sum = '0;
    acc_cnt = '0;
    expected_readings.push_back(celsius_of_mean(m));
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sender: bursts and gaps, fed from sample_queue
  int burst_left, gap_left;
  always @(negedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
    end
  end

  logic in_taken;
  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) absorb_sample(in_ch.adc_sample);
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (in_ch.valid && !in_taken) begin
      // hold request until accepted
    end else begin
      if (in_taken) void'(sample_queue.pop_front());
      if (gap_left > 0) gap_left--;
      if (feed_hold || sample_queue.size() == 0 || gap_left > 0) begin
        in_ch.valid <= 1'b0;
      end else begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          if ($urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 30);
        end
        if (gap_left > 0) begin
          in_ch.valid <= 1'b0;
        end else begin
          burst_left--;
          in_ch.valid <= 1'b1;
          in_ch.adc_sample <= sample_queue[0];
        end
      end
    end
  end

  // receiver stall pattern and checker
  int stall_mode;
  always @(negedge clk) begin
    if (cycle_cnt % 500 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= (cycle_cnt % 7) < 3;
    endcase
  end

  always @(posedge clk) begin
    reading_t exp_r;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_readings.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result temp=%0d fault=%0b",
                   out_ch.temperature_centi, out_ch.sensor_fault);
      end else begin
        exp_r = expected_readings.pop_front();
        if (out_ch.temperature_centi !== exp_r.temp ||
            out_ch.sensor_fault !== exp_r.fault) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp temp=%0d fault=%0b, got temp=%0d fault=%0b",
                     exp_r.temp, exp_r.fault, out_ch.temperature_centi,
                     out_ch.sensor_fault);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_BETA:    beta_k    = val[BETA_W-1:0];
      REG_SERIES:  series_r  = val[OHM_W-1:0];
      REG_NOMINAL: nominal_r = val[OHM_W-1:0];
      REG_NOMC:    nominal_c = val[NOMC_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain;
    while (sample_queue.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic push_group(int mean_val);
    for (int i = 0; i < GROUP_LEN; i++) sample_queue.push_back(mean_val[ADC_W-1:0]);
  endtask

  task automatic random_groups(int n_groups);
    int base;
    for (int g = 0; g < n_groups; g++) begin
      base = $urandom_range(0, 1023);
      for (int i = 0; i < GROUP_LEN; i++)
        if ($urandom_range(0, 3) == 0)
          sample_queue.push_back(ADC_W'($urandom_range(0, 1023)));
        else sample_queue.push_back(ADC_W'(base));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.adc_sample = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    mismatch_cnt = 0;
    cycle_cnt = 0;
    feed_hold = 1'b0;
    stall_mode = 0;
    beta_k = BETA_RST;
    series_r = SERIES_RST;
    nominal_r = NOMINAL_RST;
    nominal_c = NOMC_RST;
    acc_sum = '0;
    acc_cnt = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: zero mean, full scale, mid, edges
    push_group(0);
    push_group(1023);
    push_group(512);
    sample_queue.push_back(10'h3FF);
    sample_queue.push_back(10'h000);
    sample_queue.push_back(10'h155);
    sample_queue.push_back(10'h2AA);
    drain();

    // extremes of settings, incl. zero registers and out-of-range index
    write_reg(REG_BETA, 32'd1000);
    write_reg(REG_SERIES, 32'd1000000);
    write_reg(REG_NOMINAL, 32'd100);
    write_reg(REG_NOMC, 32'd100);
    write_reg(8'd9, 32'hFFFF_FFFF);
    push_group(1); push_group(1022); push_group(3);
    random_groups(8);
    drain();
    write_reg(REG_BETA, 32'hFFFF_C000);
    push_group(500);
    drain();
    write_reg(REG_BETA, 32'd10000);
    write_reg(REG_SERIES, 32'd100);
    write_reg(REG_NOMINAL, 32'd1000000);
    write_reg(REG_NOMC, 32'd0);
    push_group(1); push_group(1022);
    random_groups(8);
    drain();
    write_reg(REG_SERIES, 32'h0);
    write_reg(REG_NOMINAL, 32'hFFF0_0000);
    push_group(300);
    drain();

    // random phases with random settings
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_BETA, $urandom_range(1000, 10000));
      write_reg(REG_SERIES, $urandom_range(100, 1000000));
      write_reg(REG_NOMINAL, $urandom_range(100, 1000000));
      write_reg(REG_NOMC, $urandom_range(0, 127));
      random_groups(10);
      for (int i = 0; i < 30; i++)
        sample_queue.push_back(ADC_W'($urandom_range(0, 1023)));
      if (p == 2) begin
        // pause the sender mid-stream until every result is out
        repeat (300) @(posedge clk);
        feed_hold = 1'b1;
        while (in_ch.valid || expected_readings.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        feed_hold = 1'b0;
      end
      drain();
    end
    write_reg(REG_BETA, BETA_RST);
    write_reg(REG_SERIES, SERIES_RST);
    write_reg(REG_NOMINAL, NOMINAL_RST);
    write_reg(REG_NOMC, NOMC_RST);
    random_groups(30);
    drain();

    if (mismatch_cnt == 0 && expected_readings.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
